// ===== rtl/blr_pkg.sv =====
// Shared types, constants and codes for the line rasterizer.
package blr_pkg;

  localparam int COORD_BITS   = 10;
  localparam int DIM_BITS     = 11;
  localparam int COLOR_BITS   = 16;
  localparam int ERR_BITS     = COORD_BITS + 2;
  localparam int CMP_BITS     = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
  localparam int CFG_IDX_BITS = 2;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = 1;
  localparam int QCNT_BITS    = 2;

  typedef logic [COORD_BITS-1:0]        coord_t;
  typedef logic [DIM_BITS-1:0]          dim_t;
  typedef logic [CMP_BITS-1:0]          cmp_t;
  typedef logic [COLOR_BITS-1:0]        color_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;
  typedef logic signed [ERR_BITS:0]     err2_t;
  typedef logic [CFG_IDX_BITS-1:0]      cfg_idx_t;
  typedef logic [1:0]                   kind_t;

  localparam cfg_idx_t REG_SCREEN_WIDTH  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_SCREEN_HEIGHT = cfg_idx_t'(1);

  localparam dim_t WIDTH_RESET  = dim_t'(240);
  localparam dim_t HEIGHT_RESET = dim_t'(320);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam kind_t CMD_STEP   = 2'd0;
  localparam kind_t CMD_LOAD   = 2'd1;
  localparam kind_t CMD_REJECT = 2'd2;

  typedef struct packed {
    logic   op;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t line_color;
  } in_item_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last_pixel;
  } out_item_t;

  typedef struct packed {
    kind_t  kind;
    coord_t cur_x;
    coord_t cur_y;
    coord_t goal_x;
    coord_t goal_y;
    coord_t abs_dx;
    coord_t abs_dy;
    logic   dir_x_neg;
    logic   dir_y_neg;
    err_t   err_init;
    color_t color;
  } cmd_t;

endpackage

// ===== rtl/bresenham_line_rasterizer.sv =====
// Line rasterizer top level: a load transaction sets up a line, each step
// transaction returns the next pixel. The block accepts one transaction per
// clock until its command queue fills; the front end checks endpoints
// against the screen size registers and orders axis-aligned lines, a
// two-entry command queue decouples it from the pixel engine, which does one
// Bresenham add-and-compare per clock while out_stall allows and holds each
// pixel in an output register until it is taken. A step passes through the
// command queue and then the output register; out_stall holds its pixel
// there. A step with no active line returns nothing; a load drops any active
// line. Write screen_width (index 0) and screen_height (index 1) only while
// no transaction is in flight.
module bresenham_line_rasterizer (
  input  logic               clk,
  input  logic               rst_n,
  // configuration write port
  input  logic               cfg_we,
  input  blr_pkg::cfg_idx_t  cfg_index,
  input  blr_pkg::dim_t      cfg_wdata,
  // command channel
  input  logic               in_valid,
  output logic               in_stall,
  input  blr_pkg::in_item_t  in_item,
  // pixel channel
  output logic               out_valid,
  input  logic               out_stall,
  output blr_pkg::out_item_t out_item
);
  import blr_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_not_empty;
  logic pop;
  cmd_t q_cmd;

  // Accept transactions and turn loads into ready-to-run line set-ups.
  blr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .q_full    (q_full),
    .in_stall  (in_stall),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Hold commands while the pixel engine waits on the output side.
  blr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop_cmd   (q_cmd)
  );

  // Run the line: emit the current pixel, then advance the error term.
  blr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_cmd       (q_cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

// ===== rtl/blr_front.sv =====
// Front end: screen size registers, input acceptance and line set-up.
module blr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  blr_pkg::cfg_idx_t cfg_index,
  input  blr_pkg::dim_t     cfg_wdata,
  input  logic              in_valid,
  input  blr_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              in_stall,
  output logic              push,
  output blr_pkg::cmd_t     push_cmd
);
  import blr_pkg::*;

  dim_t   width_r, width_nxt;
  dim_t   height_r, height_nxt;
  coord_t sx, sy, ex, ey;
  logic   reject;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      if (cfg_index == REG_SCREEN_WIDTH)  width_nxt  = cfg_wdata;
      if (cfg_index == REG_SCREEN_HEIGHT) height_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    reject = (cmp_t'(in_item.start_x) >= cmp_t'(width_r))  ||
             (cmp_t'(in_item.end_x)   >= cmp_t'(width_r))  ||
             (cmp_t'(in_item.start_y) >= cmp_t'(height_r)) ||
             (cmp_t'(in_item.end_y)   >= cmp_t'(height_r));

    // Put horizontal and vertical lines in ascending order.
    sx = in_item.start_x;
    sy = in_item.start_y;
    ex = in_item.end_x;
    ey = in_item.end_y;
    if (sy == ey) begin
      if (sx > ex) begin
        sx = in_item.end_x;
        ex = in_item.start_x;
      end
    end else if (sx == ex) begin
      if (sy > ey) begin
        sy = in_item.end_y;
        ey = in_item.start_y;
      end
    end

    push_cmd.cur_x     = sx;
    push_cmd.cur_y     = sy;
    push_cmd.goal_x    = ex;
    push_cmd.goal_y    = ey;
    push_cmd.dir_x_neg = sx > ex;
    push_cmd.dir_y_neg = sy > ey;
    push_cmd.abs_dx    = push_cmd.dir_x_neg ? (sx - ex) : (ex - sx);
    push_cmd.abs_dy    = push_cmd.dir_y_neg ? (sy - ey) : (ey - sy);
    push_cmd.err_init  = err_t'(push_cmd.abs_dx) - err_t'(push_cmd.abs_dy);
    push_cmd.color     = in_item.line_color;

    if (in_item.op == OP_STEP) begin
      push_cmd.kind = CMD_STEP;
    end else if (reject) begin
      push_cmd.kind = CMD_REJECT;
    end else begin
      push_cmd.kind = CMD_LOAD;
    end
  end

endmodule

// ===== rtl/blr_queue.sv =====
// Two-entry command queue between the front end and the pixel engine.
module blr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  blr_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output blr_pkg::cmd_t pop_cmd
);
  import blr_pkg::*;

  cmd_t                 entry_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r, count_nxt;

  assign full      = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/blr_back.sv =====
// Pixel engine: line state, Bresenham step and output register.
module blr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  blr_pkg::cmd_t      q_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output blr_pkg::out_item_t out_item
);
  import blr_pkg::*;

  logic      busy_r, busy_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  coord_t    cur_x_r, cur_x_nxt;
  coord_t    cur_y_r, cur_y_nxt;
  coord_t    goal_x_r, goal_x_nxt;
  coord_t    goal_y_r, goal_y_nxt;
  coord_t    abs_dx_r, abs_dx_nxt;
  coord_t    abs_dy_r, abs_dy_nxt;
  logic      dir_x_neg_r, dir_x_neg_nxt;
  logic      dir_y_neg_r, dir_y_neg_nxt;
  err_t      err_r, err_nxt;
  color_t    color_r, color_nxt;

  logic  out_free;
  logic  last;
  logic  step_x;
  logic  step_y;
  err2_t e2;
  err2_t dx_w;
  err2_t dy_w;

  assign out_free  = !out_valid_r || !out_stall;
  assign pop       = q_not_empty && ((q_cmd.kind != CMD_STEP) || !busy_r || out_free);
  assign last      = (cur_x_r == goal_x_r) && (cur_y_r == goal_y_r);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign e2     = {err_r, 1'b0};
  assign dx_w   = err2_t'(abs_dx_r);
  assign dy_w   = err2_t'(abs_dy_r);
  assign step_x = e2 > -dy_w;
  assign step_y = e2 < dx_w;

  always_comb begin
    busy_nxt      = busy_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    goal_x_nxt    = goal_x_r;
    goal_y_nxt    = goal_y_r;
    abs_dx_nxt    = abs_dx_r;
    abs_dy_nxt    = abs_dy_r;
    dir_x_neg_nxt = dir_x_neg_r;
    dir_y_neg_nxt = dir_y_neg_r;
    err_nxt       = err_r;
    color_nxt     = color_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (pop) begin
      case (q_cmd.kind)
        CMD_LOAD: begin
          busy_nxt      = 1'b1;
          cur_x_nxt     = q_cmd.cur_x;
          cur_y_nxt     = q_cmd.cur_y;
          goal_x_nxt    = q_cmd.goal_x;
          goal_y_nxt    = q_cmd.goal_y;
          abs_dx_nxt    = q_cmd.abs_dx;
          abs_dy_nxt    = q_cmd.abs_dy;
          dir_x_neg_nxt = q_cmd.dir_x_neg;
          dir_y_neg_nxt = q_cmd.dir_y_neg;
          err_nxt       = q_cmd.err_init;
          color_nxt     = q_cmd.color;
        end
        CMD_REJECT: begin
          busy_nxt = 1'b0;
        end
        CMD_STEP: begin
          if (busy_r) begin
            out_valid_nxt            = 1'b1;
            out_item_nxt.pixel_x     = cur_x_r;
            out_item_nxt.pixel_y     = cur_y_r;
            out_item_nxt.pixel_color = color_r;
            out_item_nxt.last_pixel  = last;
            if (last) begin
              busy_nxt = 1'b0;
            end else begin
              err_nxt = err_r - (step_x ? err_t'(abs_dy_r) : '0)
                              + (step_y ? err_t'(abs_dx_r) : '0);
              if (step_x) begin
                cur_x_nxt = dir_x_neg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
              end
              if (step_y) begin
                cur_y_nxt = dir_y_neg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
              end
            end
          end
        end
        default: begin
          busy_nxt = busy_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r     <= cur_x_nxt;
    cur_y_r     <= cur_y_nxt;
    goal_x_r    <= goal_x_nxt;
    goal_y_r    <= goal_y_nxt;
    abs_dx_r    <= abs_dx_nxt;
    abs_dy_r    <= abs_dy_nxt;
    dir_x_neg_r <= dir_x_neg_nxt;
    dir_y_neg_r <= dir_y_neg_nxt;
    err_r       <= err_nxt;
    color_r     <= color_nxt;
    out_item_r  <= out_item_nxt;
  end

endmodule

// ===== rtl/blr_checker.sv =====
// Port-level checks for the line rasterizer and their bind.
module blr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input blr_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input blr_pkg::out_item_t out_item
);
  import blr_pkg::*;

  logic [3:0] credit_r, credit_nxt;
  logic       step_acc;
  logic       out_acc;

  assign step_acc = in_valid && !in_stall && (in_item.op == OP_STEP);
  assign out_acc  = out_valid && !out_stall;

  // Count step transactions not yet matched by a pixel; saturate at the top.
  always_comb begin
    credit_nxt = credit_r;
    if (step_acc && !out_acc && (credit_r != 4'hF)) begin
      credit_nxt = credit_r + 1'b1;
    end else if (out_acc && !step_acc && (credit_r != 4'h0)) begin
      credit_nxt = credit_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("pixel changed or dropped while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (credit_r != 4'h0))
    else $error("pixel delivered without a pending step");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("pixel valid right after reset");

  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (.*);
